### rtl/mptr_pkg.sv
// Package for the MIDI parser with NRPN assembly and track routing.
// Holds field widths, status and controller codes, result kinds and state types.
// No dependencies; used by the core and its checker.
package mptr_pkg;

    localparam int TRACK_COUNT_DEF      = 16;
    localparam int PARAMS_PER_TRACK_DEF = 24;

    localparam int BYTE_W  = 8;
    localparam int DATA_W  = 7;
    localparam int KIND_W  = 3;
    localparam int CH_W    = 4;
    localparam int NUM_W   = 14;
    localparam int TRACK_W = 4;
    localparam int PARAM_W = 5;
    localparam int OFF_W   = NUM_W + 2;

    // Controller numbers are offset by this amount from a track's base.
    localparam logic [OFF_W-1:0] PARAM_OFFSET = OFF_W'(8);

    localparam logic [3:0] CMD_NOTE_OFF   = 4'h8;
    localparam logic [3:0] CMD_NOTE_ON    = 4'h9;
    localparam logic [3:0] CMD_CONTROL    = 4'hB;
    localparam logic [3:0] CMD_PROGRAM    = 4'hC;
    localparam logic [3:0] CMD_CHAN_PRESS = 4'hD;
    localparam logic [3:0] CMD_SYSTEM     = 4'hF;
    localparam logic [BYTE_W-1:0] SYSEX_START = 8'hF0;

    localparam logic [DATA_W-1:0] CC_NRPN_LSB = 7'd98;
    localparam logic [DATA_W-1:0] CC_NRPN_MSB = 7'd99;
    localparam logic [DATA_W-1:0] CC_DATA_LSB = 7'd38;
    localparam logic [DATA_W-1:0] CC_DATA_MSB = 7'd6;

    typedef enum logic [KIND_W-1:0] {
        KIND_NOTE_ON     = 3'd0,
        KIND_NOTE_OFF    = 3'd1,
        KIND_CC_PASS     = 3'd2,
        KIND_NRPN_PASS   = 3'd3,
        KIND_PARAM_WRITE = 3'd4
    } kind_t;

    typedef enum logic [3:0] {
        PH_IDLE = 4'b0001,
        PH_D1   = 4'b0010,
        PH_D2   = 4'b0100,
        PH_HALT = 4'b1000
    } phase_t;

    typedef enum logic [2:0] {
        SEQ_IDLE  = 3'b001,
        SEQ_SCAN  = 3'b010,
        SEQ_FLUSH = 3'b100
    } seq_t;

endpackage

### rtl/midi_parser_nrpn_track_router_core.sv
// Top level of the MIDI parser with NRPN assembly and track routing.
// Parses bytes, keeps per-channel NRPN registers and the track map, and scans the map.
// Depends on mptr_pkg.
//
//  Channel  | Handshake          | Payload
//  ---------+--------------------+----------------------------------------------------
//  input    | in_valid/in_stall  | command, midi_byte, end_of_buffer, map_* fields
//  output   | out_valid/out_stall| event_kind, channel, key_or_number, event_value,
//           |                    | track, param_index, last
//
// A byte or map write is taken when no earlier request is still being worked on.
// A pass-through controller or completed NRPN message scans the track map one entry per cycle,
// except while a hit waits on a stalled output, through a single offset subtract and range compare.
// A note goes through the flush state to the output register; other bytes and map writes give no result.
// Reset clears the parse state, the NRPN registers and the track map at once.
// While the output is stalled, the scan holds on the next hit until the result is taken.
module midi_parser_nrpn_track_router_core #(
    parameter int TRACK_COUNT      = mptr_pkg::TRACK_COUNT_DEF,
    parameter int PARAMS_PER_TRACK = mptr_pkg::PARAMS_PER_TRACK_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic                             command,
    input  logic [mptr_pkg::BYTE_W-1:0]      midi_byte,
    input  logic                             end_of_buffer,
    input  logic [mptr_pkg::TRACK_W-1:0]     map_track,
    input  logic                             map_enabled,
    input  logic [mptr_pkg::CH_W-1:0]        map_channel,
    input  logic [mptr_pkg::NUM_W-1:0]       map_base,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [mptr_pkg::KIND_W-1:0]      event_kind,
    output logic [mptr_pkg::CH_W-1:0]        channel,
    output logic [mptr_pkg::NUM_W-1:0]       key_or_number,
    output logic [mptr_pkg::NUM_W-1:0]       event_value,
    output logic [mptr_pkg::TRACK_W-1:0]     track,
    output logic [mptr_pkg::PARAM_W-1:0]     param_index,
    output logic                             last
);

    localparam int TIDX_W   = (TRACK_COUNT > 1) ? $clog2(TRACK_COUNT) : 1;
    localparam int CHANNELS = 16;
    localparam int BYTE_W   = mptr_pkg::BYTE_W;
    localparam int DATA_W   = mptr_pkg::DATA_W;
    localparam int CH_W     = mptr_pkg::CH_W;
    localparam int NUM_W    = mptr_pkg::NUM_W;
    localparam int KIND_W   = mptr_pkg::KIND_W;
    localparam int TRACK_W  = mptr_pkg::TRACK_W;
    localparam int PARAM_W  = mptr_pkg::PARAM_W;
    localparam int OFF_W    = mptr_pkg::OFF_W;

    // Parser state.
    mptr_pkg::phase_t    phase_reg, phase_next;
    logic [BYTE_W-1:0]   status_reg, status_next;
    logic [DATA_W-1:0]   first_reg, first_next;

    // Per-channel NRPN registers. The value high byte is used as it arrives, so it
    // needs no register of its own.
    logic [DATA_W-1:0]   nrpn_num_lo_reg [CHANNELS];
    logic [DATA_W-1:0]   nrpn_num_hi_reg [CHANNELS];
    logic [DATA_W-1:0]   nrpn_val_lo_reg [CHANNELS];

    // Track map.
    logic                listen_en_reg [TRACK_COUNT];
    logic [CH_W-1:0]     listen_ch_reg [TRACK_COUNT];
    logic [NUM_W-1:0]    base_reg      [TRACK_COUNT];

    // Sequencer and the message being routed.
    mptr_pkg::seq_t      seq_reg, seq_next;
    logic [TIDX_W-1:0]   idx_reg, idx_next;
    logic [CH_W-1:0]     ctx_ch_reg, ctx_ch_next;
    logic [NUM_W-1:0]    ctx_num_reg, ctx_num_next;
    logic [NUM_W-1:0]    ctx_val_reg, ctx_val_next;
    logic [KIND_W-1:0]   ctx_kind_reg, ctx_kind_next;
    logic                pend_valid_reg, pend_valid_next;
    logic [TRACK_W-1:0]  pend_track_reg, pend_track_next;
    logic [PARAM_W-1:0]  pend_param_reg, pend_param_next;

    // Output register.
    logic                out_valid_reg, out_valid_next;
    logic [KIND_W-1:0]   out_kind_reg, out_kind_next;
    logic [CH_W-1:0]     out_ch_reg, out_ch_next;
    logic [NUM_W-1:0]    out_num_reg, out_num_next;
    logic [NUM_W-1:0]    out_val_reg, out_val_next;
    logic [TRACK_W-1:0]  out_track_reg, out_track_next;
    logic [PARAM_W-1:0]  out_param_reg, out_param_next;
    logic                out_last_reg, out_last_next;

    logic                accept;
    logic                out_free;
    logic                map_we;
    logic [TIDX_W-1:0]   map_idx;
    logic [3:0]          byte_cmd;
    logic [3:0]          st_cmd;
    logic [CH_W-1:0]     st_ch;
    logic [DATA_W-1:0]   data_bits;
    logic                num_lo_we, num_hi_we, val_lo_we;
    logic [OFF_W-1:0]    scan_diff;
    logic                scan_hit;

    assign in_stall = (seq_reg != mptr_pkg::SEQ_IDLE);
    assign accept   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    assign map_we   = accept && command && (32'(map_track) < TRACK_COUNT);
    assign map_idx  = map_track[TIDX_W-1:0];

    assign byte_cmd  = midi_byte[7:4];
    assign st_cmd    = status_reg[7:4];
    assign st_ch     = status_reg[3:0];
    assign data_bits = midi_byte[DATA_W-1:0];

    // One subtract and one range compare, shared by every track entry of the scan.
    assign scan_diff = {2'b00, ctx_num_reg} - {2'b00, base_reg[idx_reg]}
                       - mptr_pkg::PARAM_OFFSET;
    assign scan_hit  = listen_en_reg[idx_reg] && (listen_ch_reg[idx_reg] == ctx_ch_reg)
                       && !scan_diff[OFF_W-1]
                       && (32'(scan_diff[OFF_W-2:0]) < PARAMS_PER_TRACK);

    always_comb
    begin
        phase_next      = phase_reg;
        status_next     = status_reg;
        first_next      = first_reg;
        seq_next        = seq_reg;
        idx_next        = idx_reg;
        ctx_ch_next     = ctx_ch_reg;
        ctx_num_next    = ctx_num_reg;
        ctx_val_next    = ctx_val_reg;
        ctx_kind_next   = ctx_kind_reg;
        pend_valid_next = pend_valid_reg;
        pend_track_next = pend_track_reg;
        pend_param_next = pend_param_reg;
        num_lo_we       = 1'b0;
        num_hi_we       = 1'b0;
        val_lo_we       = 1'b0;

        out_valid_next  = out_valid_reg && out_stall;
        out_kind_next   = out_kind_reg;
        out_ch_next     = out_ch_reg;
        out_num_next    = out_num_reg;
        out_val_next    = out_val_reg;
        out_track_next  = out_track_reg;
        out_param_next  = out_param_reg;
        out_last_next   = out_last_reg;

        case (seq_reg)
            mptr_pkg::SEQ_IDLE:
            begin
                if (accept && !command)
                begin
                    case (phase_reg)
                        mptr_pkg::PH_IDLE:
                        begin
                            if (!midi_byte[7] || byte_cmd == mptr_pkg::CMD_CHAN_PRESS
                                || midi_byte == mptr_pkg::SYSEX_START)
                            begin
                                phase_next = mptr_pkg::PH_HALT;
                            end
                            else if (byte_cmd != mptr_pkg::CMD_SYSTEM)
                            begin
                                status_next = midi_byte;
                                phase_next  = mptr_pkg::PH_D1;
                            end
                        end
                        mptr_pkg::PH_D1:
                        begin
                            first_next = data_bits;
                            phase_next = (st_cmd == mptr_pkg::CMD_PROGRAM)
                                         ? mptr_pkg::PH_IDLE : mptr_pkg::PH_D2;
                        end
                        mptr_pkg::PH_D2:
                        begin
                            phase_next   = mptr_pkg::PH_IDLE;
                            ctx_ch_next  = st_ch;
                            ctx_num_next = NUM_W'(first_reg);
                            ctx_val_next = NUM_W'(data_bits);
                            pend_valid_next = 1'b0;
                            idx_next        = '0;
                            case (st_cmd)
                                mptr_pkg::CMD_NOTE_OFF:
                                begin
                                    ctx_kind_next = mptr_pkg::KIND_NOTE_OFF;
                                    seq_next      = mptr_pkg::SEQ_FLUSH;
                                end
                                mptr_pkg::CMD_NOTE_ON:
                                begin
                                    // A note on with zero velocity is reported as note off.
                                    ctx_kind_next = (data_bits != '0)
                                                    ? mptr_pkg::KIND_NOTE_ON
                                                    : mptr_pkg::KIND_NOTE_OFF;
                                    seq_next      = mptr_pkg::SEQ_FLUSH;
                                end
                                mptr_pkg::CMD_CONTROL:
                                begin
                                    if (first_reg == mptr_pkg::CC_NRPN_LSB)
                                    begin
                                        num_lo_we = 1'b1;
                                    end
                                    else if (first_reg == mptr_pkg::CC_NRPN_MSB)
                                    begin
                                        num_hi_we = 1'b1;
                                    end
                                    else if (first_reg == mptr_pkg::CC_DATA_LSB)
                                    begin
                                        val_lo_we = 1'b1;
                                    end
                                    else if (first_reg == mptr_pkg::CC_DATA_MSB)
                                    begin
                                        ctx_num_next  = {nrpn_num_hi_reg[st_ch],
                                                         nrpn_num_lo_reg[st_ch]};
                                        ctx_val_next  = {data_bits, nrpn_val_lo_reg[st_ch]};
                                        ctx_kind_next = mptr_pkg::KIND_NRPN_PASS;
                                        seq_next      = mptr_pkg::SEQ_SCAN;
                                    end
                                    else
                                    begin
                                        ctx_kind_next = mptr_pkg::KIND_CC_PASS;
                                        seq_next      = mptr_pkg::SEQ_SCAN;
                                    end
                                end
                                default:
                                begin
                                end
                            endcase
                        end
                        default:
                        begin
                        end
                    endcase
                    if (end_of_buffer)
                    begin
                        phase_next = mptr_pkg::PH_IDLE;
                    end
                end
            end

            mptr_pkg::SEQ_SCAN:
            begin
                // A new hit can only displace the held one once the output can take it.
                if (!(scan_hit && pend_valid_reg && !out_free))
                begin
                    if (scan_hit)
                    begin
                        if (pend_valid_reg)
                        begin
                            out_valid_next = 1'b1;
                            out_kind_next  = mptr_pkg::KIND_PARAM_WRITE;
                            out_ch_next    = ctx_ch_reg;
                            out_num_next   = ctx_num_reg;
                            out_val_next   = ctx_val_reg;
                            out_track_next = pend_track_reg;
                            out_param_next = pend_param_reg;
                            out_last_next  = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_track_next = TRACK_W'(idx_reg);
                        pend_param_next = scan_diff[PARAM_W-1:0];
                    end
                    if (32'(idx_reg) == TRACK_COUNT - 1)
                    begin
                        seq_next = mptr_pkg::SEQ_FLUSH;
                    end
                    else
                    begin
                        idx_next = idx_reg + TIDX_W'(1);
                    end
                end
            end

            mptr_pkg::SEQ_FLUSH:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_ch_next    = ctx_ch_reg;
                    out_num_next   = ctx_num_reg;
                    out_val_next   = ctx_val_reg;
                    out_last_next  = 1'b1;
                    if (pend_valid_reg)
                    begin
                        out_kind_next  = mptr_pkg::KIND_PARAM_WRITE;
                        out_track_next = pend_track_reg;
                        out_param_next = pend_param_reg;
                    end
                    else
                    begin
                        out_kind_next  = ctx_kind_reg;
                        out_track_next = '0;
                        out_param_next = '0;
                    end
                    pend_valid_next = 1'b0;
                    seq_next        = mptr_pkg::SEQ_IDLE;
                end
            end

            default:
            begin
                seq_next = mptr_pkg::SEQ_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= mptr_pkg::PH_IDLE;
            status_reg     <= '0;
            first_reg      <= '0;
            seq_reg        <= mptr_pkg::SEQ_IDLE;
            idx_reg        <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            for (int c = 0; c < CHANNELS; c++)
            begin
                nrpn_num_lo_reg[c] <= '0;
                nrpn_num_hi_reg[c] <= '0;
                nrpn_val_lo_reg[c] <= '0;
            end
            for (int t = 0; t < TRACK_COUNT; t++)
            begin
                listen_en_reg[t] <= 1'b0;
                listen_ch_reg[t] <= '0;
                base_reg[t]      <= '0;
            end
        end
        else
        begin
            phase_reg      <= phase_next;
            status_reg     <= status_next;
            first_reg      <= first_next;
            seq_reg        <= seq_next;
            idx_reg        <= idx_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            if (num_lo_we)
            begin
                nrpn_num_lo_reg[st_ch] <= data_bits;
            end
            if (num_hi_we)
            begin
                nrpn_num_hi_reg[st_ch] <= data_bits;
            end
            if (val_lo_we)
            begin
                nrpn_val_lo_reg[st_ch] <= data_bits;
            end
            if (map_we)
            begin
                listen_en_reg[map_idx] <= map_enabled;
                listen_ch_reg[map_idx] <= map_channel;
                base_reg[map_idx]      <= map_base;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ctx_ch_reg     <= ctx_ch_next;
        ctx_num_reg    <= ctx_num_next;
        ctx_val_reg    <= ctx_val_next;
        ctx_kind_reg   <= ctx_kind_next;
        pend_track_reg <= pend_track_next;
        pend_param_reg <= pend_param_next;
        out_kind_reg   <= out_kind_next;
        out_ch_reg     <= out_ch_next;
        out_num_reg    <= out_num_next;
        out_val_reg    <= out_val_next;
        out_track_reg  <= out_track_next;
        out_param_reg  <= out_param_next;
        out_last_reg   <= out_last_next;
    end

    assign out_valid     = out_valid_reg;
    assign event_kind    = out_kind_reg;
    assign channel       = out_ch_reg;
    assign key_or_number = out_num_reg;
    assign event_value   = out_val_reg;
    assign track         = out_track_reg;
    assign param_index   = out_param_reg;
    assign last          = out_last_reg;

endmodule

### rtl/mptr_checker.sv
// Port-level checker for the MIDI parser and track router core, with its bind.
// Watches the request and result channels over time.
// Depends on mptr_pkg and midi_parser_nrpn_track_router_core.
module mptr_checker #(
    parameter int PARAMS_PER_TRACK = mptr_pkg::PARAMS_PER_TRACK_DEF
) (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             in_stall,
    input logic                             out_valid,
    input logic                             out_stall,
    input logic [mptr_pkg::KIND_W-1:0]      event_kind,
    input logic [mptr_pkg::CH_W-1:0]        channel,
    input logic [mptr_pkg::NUM_W-1:0]       key_or_number,
    input logic [mptr_pkg::NUM_W-1:0]       event_value,
    input logic [mptr_pkg::TRACK_W-1:0]     track,
    input logic [mptr_pkg::PARAM_W-1:0]     param_index,
    input logic                             last
);

    // A stalled result stays and does not change.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid
        && $stable({event_kind, channel, key_or_number, event_value, track, param_index, last}))
        else $error("result changed while stalled");

    // Notes and pass-through messages are single results with no track target.
    a_single: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && event_kind != mptr_pkg::KIND_PARAM_WRITE
        |-> last && track == '0 && param_index == '0)
        else $error("pass-through result with track fields or without last");

    // Parameter writes land inside a track's slot range.
    a_slot: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && event_kind == mptr_pkg::KIND_PARAM_WRITE
        |-> 32'(param_index) < PARAMS_PER_TRACK)
        else $error("parameter slot out of range");

    // While a request still has results to come, no new request is taken.
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last |-> in_stall)
        else $error("request taken before the previous one finished");

endmodule

bind midi_parser_nrpn_track_router_core mptr_checker #(
    .PARAMS_PER_TRACK(PARAMS_PER_TRACK)
) u_mptr_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_stall      (in_stall),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .event_kind    (event_kind),
    .channel       (channel),
    .key_or_number (key_or_number),
    .event_value   (event_value),
    .track         (track),
    .param_index   (param_index),
    .last          (last)
);
